FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU key/value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic match;
      logic better;
   } cmp_flags_type;

endpackage

FILE: hdl/lfu_cache_lookup_insert.sv
// ----------------------------------------------------------------------------
// lfu_cache_lookup_insert
// Fully associative key/value cache with LFU replacement, LRU tie break.
// ----------------------------------------------------------------------------
// Request channel (req_*): one beat per get or put, action in tuser.
// Response channel (rsp_*): exactly one beat per request, in order.
// csr_wr_en/csr_wr_data set the number of entries in use; write only when idle.
//
// Each request walks the entry memory once to find the key, the first free
// slot and the eviction victim, through the single read port and the
// compare unit. A request that changes state walks it again to age the
// recency ranks and write the target entry. After the decide state, a get
// miss or a dropped put goes straight to the finish state; any other request
// passes through the second walk first.
// req_tready is high only between requests.
//
// Reset empties the cache and sets the capacity to 16; the entry memory
// itself is not cleared. A stalled response is held in the output register;
// the next request is taken meanwhile and waits in its finish state.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_insert #(
   parameter int CAPACITY   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lookup_key [31:0], write_value [63:32]
   input  logic [0:0]  req_tuser,   // action [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // read_value [31:0], evicted_key [63:32]
   output logic [1:0]  rsp_tuser,   // hit [0], evicted [1]
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import lfu_pkg::*;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int CNT_LO = RANK_W;
   localparam int VAL_LO = RANK_W + COUNT_BITS;
   localparam int KEY_LO = VAL_LO + DATA_W;
   localparam int WORD_W = KEY_LO + DATA_W;

   localparam logic [CMP_W-1:0]      CAP_LIMIT = CMP_W'(CAPACITY);
   localparam logic [OCC_W-1:0]      IDX_END   = OCC_W'(CAPACITY);
   localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
   localparam logic [RANK_W-1:0]     RANK_TOP  = '0;

   seq_state_type state_ff, state_in;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CMP_W-1:0]      cap_eff_ff, cap_eff_in;
   logic                  act_ff, act_in;
   logic [DATA_W-1:0]     key_ff, key_in;
   logic [DATA_W-1:0]     wval_ff, wval_in;

   logic [OCC_W-1:0]      idx_ff, idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;

   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [DATA_W-1:0]     found_val_ff, found_val_in;
   logic [COUNT_BITS-1:0] found_cnt_ff, found_cnt_in;
   logic [RANK_W-1:0]     found_rank_ff, found_rank_in;
   logic                  free_ff, free_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  vic_ff, vic_in;
   logic [IDX_W-1:0]      vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0] vic_cnt_ff, vic_cnt_in;
   logic [RANK_W-1:0]     vic_rank_ff, vic_rank_in;
   logic [DATA_W-1:0]     vic_key_ff, vic_key_in;

   logic [IDX_W-1:0]      tgt_idx_ff, tgt_idx_in;
   logic [WORD_W-1:0]     tgt_word_ff, tgt_word_in;
   logic [RANK_W-1:0]     limit_ff, limit_in;
   logic                  age_all_ff, age_all_in;

   logic                  res_hit_ff, res_hit_in;
   logic [DATA_W-1:0]     res_rd_ff, res_rd_in;
   logic                  res_ev_ff, res_ev_in;
   logic [DATA_W-1:0]     res_evk_ff, res_evk_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [WORD_W-1:0]     mem_wr_data;
   logic                  mem_rd_en;
   logic [WORD_W-1:0]     rd_word;

   logic [DATA_W-1:0]     rd_key;
   logic [DATA_W-1:0]     rd_val;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [RANK_W-1:0]     rd_rank;
   logic                  cur_valid;
   logic [COUNT_BITS-1:0] bump_cnt;
   logic [CMP_W-1:0]      cap_ext;
   cmp_flags_type         flags;

   assign rd_key    = rd_word[KEY_LO +: DATA_W];
   assign rd_val    = rd_word[VAL_LO +: DATA_W];
   assign rd_cnt    = rd_word[CNT_LO +: COUNT_BITS];
   assign rd_rank   = rd_word[RANK_W-1:0];
   assign cur_valid = valid_ff[chk_idx_ff];
   assign bump_cnt  = (found_cnt_ff == CNT_MAX) ? CNT_MAX : COUNT_BITS'(found_cnt_ff + 1'b1);
   assign cap_ext   = CMP_W'(cap_ff);

   lfu_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   lfu_cmp #(
      .COUNT_BITS (COUNT_BITS),
      .RANK_W     (RANK_W)
   ) u_cmp (
      .cand_valid (cur_valid),
      .cand_key   (rd_key),
      .cand_count (rd_cnt),
      .cand_rank  (rd_rank),
      .look_key   (key_ff),
      .best_have  (vic_ff),
      .best_count (vic_cnt_ff),
      .best_rank  (vic_rank_ff),
      .flags      (flags)
   );

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      cap_eff_in    = cap_eff_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      idx_in        = idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_val_in  = found_val_ff;
      found_cnt_in  = found_cnt_ff;
      found_rank_in = found_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      vic_in        = vic_ff;
      vic_idx_in    = vic_idx_ff;
      vic_cnt_in    = vic_cnt_ff;
      vic_rank_in   = vic_rank_ff;
      vic_key_in    = vic_key_ff;
      tgt_idx_in    = tgt_idx_ff;
      tgt_word_in   = tgt_word_ff;
      limit_in      = limit_ff;
      age_all_in    = age_all_ff;
      res_hit_in    = res_hit_ff;
      res_rd_in     = res_rd_ff;
      res_ev_in     = res_ev_ff;
      res_evk_in    = res_evk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = chk_idx_ff;
      mem_wr_data   = tgt_word_ff;
      mem_rd_en     = 1'b0;
      req_tready    = 1'b0;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in     = req_tuser[0];
               key_in     = req_tdata[31:0];
               wval_in    = req_tdata[63:32];
               cap_eff_in = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
               found_in   = 1'b0;
               free_in    = 1'b0;
               vic_in     = 1'b0;
               idx_in     = '0;
               chk_vld_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (idx_ff != IDX_END) begin
               mem_rd_en  = 1'b1;
               idx_in     = OCC_W'(idx_ff + 1'b1);
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
               state_in   = ST_DECIDE;
            end
            if (chk_vld_ff) begin
               if (flags.match && !found_ff) begin
                  found_in      = 1'b1;
                  found_idx_in  = chk_idx_ff;
                  found_val_in  = rd_val;
                  found_cnt_in  = rd_cnt;
                  found_rank_in = rd_rank;
               end
               if (!cur_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (flags.better) begin
                  vic_in      = 1'b1;
                  vic_idx_in  = chk_idx_ff;
                  vic_cnt_in  = rd_cnt;
                  vic_rank_in = rd_rank;
                  vic_key_in  = rd_key;
               end
            end
         end

         ST_DECIDE: begin
            res_hit_in = found_ff;
            res_rd_in  = '0;
            res_ev_in  = 1'b0;
            res_evk_in = '0;
            state_in   = ST_FINISH;
            idx_in     = '0;
            chk_vld_in = 1'b0;
            age_all_in = 1'b0;
            if (act_ff == ACT_GET) begin
               if (found_ff) begin
                  res_rd_in   = found_val_ff;
                  tgt_idx_in  = found_idx_ff;
                  tgt_word_in = {key_ff, found_val_ff, bump_cnt, RANK_TOP};
                  limit_in    = found_rank_ff;
                  state_in    = ST_UPDATE;
               end
            end else if (cap_eff_ff != '0) begin
               if (found_ff) begin
                  tgt_idx_in  = found_idx_ff;
                  tgt_word_in = {key_ff, wval_ff, bump_cnt, RANK_TOP};
                  limit_in    = found_rank_ff;
                  state_in    = ST_UPDATE;
               end else if (CMP_W'(occ_ff) < cap_eff_ff) begin
                  tgt_idx_in            = free_idx_ff;
                  tgt_word_in           = {key_ff, wval_ff, CNT_ONE, RANK_TOP};
                  age_all_in            = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  occ_in                = OCC_W'(occ_ff + 1'b1);
                  state_in              = ST_UPDATE;
               end else if (vic_ff) begin
                  res_ev_in   = 1'b1;
                  res_evk_in  = vic_key_ff;
                  tgt_idx_in  = vic_idx_ff;
                  tgt_word_in = {key_ff, wval_ff, CNT_ONE, RANK_TOP};
                  limit_in    = vic_rank_ff;
                  state_in    = ST_UPDATE;
               end
            end
         end

         ST_UPDATE: begin
            if (idx_ff != IDX_END) begin
               mem_rd_en  = 1'b1;
               idx_in     = OCC_W'(idx_ff + 1'b1);
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
               state_in   = ST_FINISH;
            end
            if (chk_vld_ff) begin
               if (chk_idx_ff == tgt_idx_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = tgt_word_ff;
               end else if (cur_valid && (age_all_ff || (rd_rank < limit_ff))) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {rd_word[WORD_W-1:RANK_W], RANK_W'(rd_rank + 1'b1)};
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_evk_ff, res_rd_ff};
               rsp_user_in  = {res_ev_ff, res_hit_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_eff_ff    <= cap_eff_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_val_ff  <= found_val_in;
      found_cnt_ff  <= found_cnt_in;
      found_rank_ff <= found_rank_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      vic_ff        <= vic_in;
      vic_idx_ff    <= vic_idx_in;
      vic_cnt_ff    <= vic_cnt_in;
      vic_rank_ff   <= vic_rank_in;
      vic_key_ff    <= vic_key_in;
      tgt_idx_ff    <= tgt_idx_in;
      tgt_word_ff   <= tgt_word_in;
      limit_ff      <= limit_in;
      age_all_ff    <= age_all_in;
      res_hit_ff    <= res_hit_in;
      res_rd_ff     <= res_rd_in;
      res_ev_ff     <= res_ev_in;
      res_evk_ff    <= res_evk_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: hdl/lfu_mem.sv
// ----------------------------------------------------------------------------
// lfu_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 84,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] word_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= word_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lfu_cmp.sv
// ----------------------------------------------------------------------------
// lfu_cmp
// Per-entry compare unit: key match and least-count, least-recent victim test.
// ----------------------------------------------------------------------------
module lfu_cmp #(
   parameter int COUNT_BITS = 16,
   parameter int RANK_W     = 4
) (
   input  logic                   cand_valid,
   input  logic [31:0]            cand_key,
   input  logic [COUNT_BITS-1:0]  cand_count,
   input  logic [RANK_W-1:0]      cand_rank,
   input  logic [31:0]            look_key,
   input  logic                   best_have,
   input  logic [COUNT_BITS-1:0]  best_count,
   input  logic [RANK_W-1:0]      best_rank,
   output lfu_pkg::cmp_flags_type flags
);
   import lfu_pkg::*;

   logic fewer;
   logic older;

   assign fewer = cand_count < best_count;
   assign older = (cand_count == best_count) && (cand_rank > best_rank);

   assign flags.match  = cand_valid && (cand_key == look_key);
   assign flags.better = cand_valid && (!best_have || fewer || older);

endmodule

FILE: hdl/lfu_chk.sv
// ----------------------------------------------------------------------------
// lfu_chk
// Port-level checks for the LFU cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,   // read_value [31:0], evicted_key [63:32]
   input logic [1:0]  rsp_tuser    // hit [0], evicted [1]
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_hit_evict_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("hit and evicted both set");

   a_read_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[31:0] != 32'd0) |-> rsp_tuser[0])
      else $error("read value without hit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after an accepted beat");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

endmodule

bind lfu_cache_lookup_insert lfu_chk u_lfu_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
